// ===== sv/set_assoc_cache_hit_miss_core_macros.svh =====
// assertion macros shared by the cache tag store rtl
`ifndef SET_ASSOC_CACHE_HIT_MISS_CORE_MACROS_SVH
`define SET_ASSOC_CACHE_HIT_MISS_CORE_MACROS_SVH

// same-cycle implication
`define SCAHM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scahm assertion failed");

// next-cycle implication
`define SCAHM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scahm assertion failed");

`endif

// ===== sv/scahm_pkg.sv =====
// shared types and constants of the cache tag store
package scahm_pkg;

   localparam int MAX_SETS   = 256;
   localparam int MAX_WAYS   = 8;
   localparam int ADDR_W     = 31;
   localparam int TAG_W      = ADDR_W;
   localparam int SET_CNT_W  = 9;
   localparam int WAY_CNT_W  = 4;
   localparam int SET_IDX_W  = $clog2(MAX_SETS);
   localparam int WAY_IDX_W  = $clog2(MAX_WAYS);
   localparam int DIV_CNT_W  = $clog2(ADDR_W);
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 9;
   localparam int REQ_DATA_W = ((ADDR_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = 8;

   localparam logic [SET_CNT_W-1:0] SET_COUNT_RESET = SET_CNT_W'(64);
   localparam logic [WAY_CNT_W-1:0] WAY_COUNT_RESET = WAY_CNT_W'(4);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SET_COUNT = CSR_IDX_W'(0),
      CSR_WAY_COUNT = CSR_IDX_W'(1)
   } csr_index_type;

   typedef logic [TAG_W-1:0] tag_type;

   typedef struct packed {
      tag_type [MAX_WAYS-1:0]  tags;
      logic [MAX_WAYS-1:0]     valid;
      logic [WAY_IDX_W-1:0]    victim;
   } set_row_type;

   typedef struct packed {
      logic                    done;
      tag_type                 quotient;
      logic [SET_IDX_W-1:0]    remainder;
   } div_result_type;

endpackage

// ===== sv/scahm_divider.sv =====
// iterative restoring divider, one quotient bit per cycle
module scahm_divider import scahm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [ADDR_W-1:0]     dividend,
   input  logic [SET_CNT_W-1:0]  divisor,
   output div_result_type        result
);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [DIV_CNT_W-1:0]   count_ff, count_in;
   logic [ADDR_W-1:0]      quot_ff, quot_in;
   logic [SET_IDX_W-1:0]   rem_ff, rem_in;
   logic [SET_CNT_W-1:0]   divisor_ff, divisor_in;
   logic [SET_IDX_W:0]     partial;
   logic [SET_IDX_W:0]     diff;
   logic                   ge;

   always_comb begin
      partial    = {rem_ff, quot_ff[ADDR_W-1]};
      ge         = partial >= (SET_IDX_W+1)'(divisor_ff);
      diff       = partial - (SET_IDX_W+1)'(divisor_ff);
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = DIV_CNT_W'(ADDR_W - 1);
         quot_in    = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         quot_in  = {quot_ff[ADDR_W-2:0], ge};
         rem_in   = ge ? diff[SET_IDX_W-1:0] : partial[SET_IDX_W-1:0];
         count_in = count_ff - DIV_CNT_W'(1);
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff   <= count_in;
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign result.done      = done_ff;
   assign result.quotient  = quot_ff;
   assign result.remainder = rem_ff;

endmodule

// ===== sv/scahm_set_store.sv =====
// set memory: one row of tags, valid bits and victim pointer per set
module scahm_set_store import scahm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  logic [SET_IDX_W-1:0]  rd_addr,
   output set_row_type           rd_row,
   input  logic                  wr_en,
   input  logic [SET_IDX_W-1:0]  wr_addr,
   input  set_row_type           wr_row
);

   set_row_type            row_mem_ff [MAX_SETS];
   set_row_type            rd_data_ff;
   logic [MAX_SETS-1:0]    row_init_ff;
   logic                   rd_init_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem_ff[wr_addr] <= wr_row;
      end
      if (rd_en) begin
         rd_data_ff <= row_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_init_ff <= '0;
         rd_init_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            row_init_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_init_ff <= row_init_ff[rd_addr];
         end
      end
   end

   // untouched row reads as empty
   always_comb begin
      rd_row = rd_data_ff;
      if (!rd_init_ff) begin
         rd_row.valid  = '0;
         rd_row.victim = '0;
      end
   end

endmodule

// ===== sv/scahm_way_select.sv =====
// tag compare, fill way choice and round-robin victim update for one set
module scahm_way_select import scahm_pkg::*; (
   input  set_row_type           row,
   input  tag_type               tag,
   input  logic [WAY_CNT_W-1:0]  ways,
   output logic                  hit,
   output set_row_type           new_row
);

   logic                   free_found;
   logic [WAY_IDX_W-1:0]   free_way;
   logic [WAY_IDX_W-1:0]   victim;
   logic [WAY_IDX_W-1:0]   victim_next;
   logic                   in_use;

   always_comb begin
      hit        = 1'b0;
      free_found = 1'b0;
      free_way   = '0;
      in_use     = 1'b0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         in_use = WAY_CNT_W'(w) < ways;
         if (in_use && row.valid[w] && row.tags[w] == tag) begin
            hit = 1'b1;
         end
         if (in_use && !row.valid[w] && !free_found) begin
            free_found = 1'b1;
            free_way   = WAY_IDX_W'(w);
         end
      end

      // pointer may be stale after the way count shrank
      victim = row.victim;
      for (int i = 0; i < MAX_WAYS - 1; i++) begin
         if (WAY_CNT_W'(victim) >= ways) begin
            victim = WAY_IDX_W'(WAY_CNT_W'(victim) - ways);
         end
      end
      if (WAY_CNT_W'(victim) + WAY_CNT_W'(1) == ways) begin
         victim_next = '0;
      end else begin
         victim_next = victim + WAY_IDX_W'(1);
      end

      new_row = row;
      if (!hit) begin
         if (free_found) begin
            new_row.valid[free_way] = 1'b1;
            new_row.tags[free_way]  = tag;
         end else begin
            new_row.valid[victim] = 1'b1;
            new_row.tags[victim]  = tag;
            new_row.victim        = victim_next;
         end
      end
   end

endmodule

// ===== sv/set_assoc_cache_hit_miss_core.sv =====
// top level of the set-associative cache tag store with round-robin replacement
//
// req channel: one address word per access (req_tdata[30:0]).
// rsp channel: one word per access, rsp_tdata[0] set on a hit.
// csr channel: register 0 is the set count, register 1 the way count; always ready,
// to be written only while no access is in flight.
// an accepted address is divided by the set count in a radix-2 divider, then its
// set row is read from the set memory into a read register and written back with
// the updated tags, valid bits and victim pointer in the cycle the result is
// registered. the next address can be taken in the cycle the result shows, but
// not before the previous address has been written back.
// the result register lets a new address in while a result still waits; a stalled
// rsp side holds the block before the write-back until the register frees.
// reset clears a per-set flag so every set reads empty at once, with no clearing
// pass; the set count returns to 64 and the way count to 4.
module set_assoc_cache_hit_miss_core import scahm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // address, zero pad
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // hit, zero pad
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

`include "set_assoc_cache_hit_miss_core_macros.svh"

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIVIDE,
      S_LOOKUP
   } state_type;

   state_type               state_ff;
   logic                    rsp_tvalid_ff;
   logic                    rsp_hit_ff;
   tag_type                 tag_ff;
   logic [SET_IDX_W-1:0]    set_idx_ff;
   logic [SET_CNT_W-1:0]    set_count_ff;
   logic [WAY_CNT_W-1:0]    way_count_ff;

   logic                    accept;
   logic                    slot_free;
   logic [SET_CNT_W-1:0]    sets_eff;
   logic [WAY_CNT_W-1:0]    ways_eff;
   div_result_type          div_result;
   logic                    st_rd_en;
   logic                    st_wr_en;
   set_row_type             rd_row;
   set_row_type             new_row;
   logic                    hit;

   assign csr_ready  = 1'b1;
   assign req_tready = state_ff == S_IDLE;
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_tvalid_ff || rsp_tready;
   assign st_rd_en   = state_ff == S_DIVIDE && div_result.done;
   assign st_wr_en   = state_ff == S_LOOKUP && slot_free;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {(RSP_DATA_W-1)'(0), rsp_hit_ff};

   always_comb begin
      if (set_count_ff == '0) begin
         sets_eff = SET_CNT_W'(1);
      end else if (set_count_ff > SET_CNT_W'(MAX_SETS)) begin
         sets_eff = SET_CNT_W'(MAX_SETS);
      end else begin
         sets_eff = set_count_ff;
      end
      if (way_count_ff == '0) begin
         ways_eff = WAY_CNT_W'(1);
      end else if (way_count_ff > WAY_CNT_W'(MAX_WAYS)) begin
         ways_eff = WAY_CNT_W'(MAX_WAYS);
      end else begin
         ways_eff = way_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_count_ff <= SET_COUNT_RESET;
         way_count_ff <= WAY_COUNT_RESET;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_SET_COUNT: begin
               set_count_ff <= csr_data[SET_CNT_W-1:0];
            end
            CSR_WAY_COUNT: begin
               way_count_ff <= csr_data[WAY_CNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   scahm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .dividend (req_tdata[ADDR_W-1:0]),
      .divisor  (sets_eff),
      .result   (div_result)
   );

   scahm_set_store u_set_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (st_rd_en),
      .rd_addr (div_result.remainder),
      .rd_row  (rd_row),
      .wr_en   (st_wr_en),
      .wr_addr (set_idx_ff),
      .wr_row  (new_row)
   );

   scahm_way_select u_way_select (
      .row     (rd_row),
      .tag     (tag_ff),
      .ways    (ways_eff),
      .hit     (hit),
      .new_row (new_row)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (rsp_tvalid_ff && rsp_tready && !st_wr_en) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_DIVIDE;
               end
            end
            S_DIVIDE: begin
               if (div_result.done) begin
                  tag_ff     <= div_result.quotient;
                  set_idx_ff <= div_result.remainder;
                  state_ff   <= S_LOOKUP;
               end
            end
            S_LOOKUP: begin
               if (slot_free) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_hit_ff    <= hit;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   `SCAHM_ASSERT_NOW(a_done_in_divide, clock, reset, div_result.done, state_ff == S_DIVIDE)
   `SCAHM_ASSERT_NEXT(a_read_then_lookup, clock, reset, st_rd_en, state_ff == S_LOOKUP && !req_tready)
   `SCAHM_ASSERT_NEXT(a_write_gives_word, clock, reset, st_wr_en, rsp_tvalid_ff && state_ff == S_IDLE)
   `SCAHM_ASSERT_NEXT(a_accept_no_write, clock, reset, accept, !st_wr_en && !st_rd_en)

endmodule

// ===== tb/testbench.sv =====
// testbench for the set-associative cache tag store, directed and random accesses checked against a tag model
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import scahm_pkg::*;

   localparam longint unsigned ADDR_MAX = (64'd1 << ADDR_W) - 1;
   localparam int IDLE_PCT = 22;
   localparam int PHASES = 10;
   localparam int PHASE_ITEMS = 183;
   localparam int HOLD_AT = 300;
   localparam int HOLD_CYCLES = 400;
   localparam int QUIET_FIRST = 700;
   localparam int QUIET_LAST = 1000;
   localparam int TAIL_CYCLES = 60;
   localparam int CSR_SPARE_FIRST = 2;

   class hit_scoreboard;
      logic [SET_CNT_W-1:0] set_count_reg;
      logic [WAY_CNT_W-1:0] way_count_reg;
      bit                   valid_bits [MAX_SETS*MAX_WAYS];
      tag_type              tag_bits [MAX_SETS*MAX_WAYS];
      logic [WAY_IDX_W-1:0] victim [MAX_SETS];
      bit                   expected_hits [$];
      int                   errors;
      int                   responses;

      function new();
         set_count_reg = SET_COUNT_RESET;
         way_count_reg = WAY_COUNT_RESET;
         foreach (valid_bits[i]) begin
            valid_bits[i] = 1'b0;
            tag_bits[i] = '0;
         end
         foreach (victim[i]) victim[i] = '0;
         errors = 0;
         responses = 0;
      endfunction

      function int unsigned sets_in_use();
         if (set_count_reg == 0) return 1;
         if (set_count_reg > MAX_SETS) return MAX_SETS;
         return set_count_reg;
      endfunction

      function int unsigned ways_in_use();
         if (way_count_reg == 0) return 1;
         if (way_count_reg > MAX_WAYS) return MAX_WAYS;
         return way_count_reg;
      endfunction

      function int pending();
         return expected_hits.size();
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         if (index == CSR_SET_COUNT) set_count_reg = value;
         else if (index == CSR_WAY_COUNT) way_count_reg = value[WAY_CNT_W-1:0];
      endfunction

      // look up one address, fill or replace on a miss, queue the hit flag
      function void note_access(logic [ADDR_W-1:0] address);
         int unsigned sets, ways, set_idx, base, way, pick;
         tag_type tag;
         bit hit, placed;
         sets = sets_in_use();
         ways = ways_in_use();
         set_idx = address % sets;
         tag = tag_type'(address / sets);
         base = set_idx * MAX_WAYS;
         hit = 1'b0;
         placed = 1'b0;
         for (way = 0; way < ways && !hit; way++)
            if (valid_bits[base+way] && tag_bits[base+way] == tag) hit = 1'b1;
         if (!hit) begin
            for (way = 0; way < ways && !placed; way++)
               if (!valid_bits[base+way]) begin
                  valid_bits[base+way] = 1'b1;
                  tag_bits[base+way] = tag;
                  placed = 1'b1;
               end
            if (!placed) begin
               pick = victim[set_idx] % ways;
               tag_bits[base+pick] = tag;
               victim[set_idx] = WAY_IDX_W'((pick + 1) % ways);
            end
         end
         expected_hits.push_back(hit);
      endfunction

      function void check_response(logic [RSP_DATA_W-1:0] word);
         bit want;
         responses++;
         if (expected_hits.size() == 0) begin
            errors++;
            $error("hit: no word expected, actual %0b", word[0]);
            return;
         end
         want = expected_hits.pop_front();
         if (word[0] !== want) begin
            errors++;
            $error("hit mismatch: expected %0b actual %0b", want, word[0]);
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   hit_scoreboard sb = new();
   int accepted = 0;
   bit hold_done = 1'b0;

   set_assoc_cache_hit_miss_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
   end

   // receiver: random stalls, one long hold-off, a quiet stretch
   initial begin
      @(posedge clock);
      forever begin
         if (!hold_done && sb.responses >= HOLD_AT) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= (sb.responses >= QUIET_FIRST && sb.responses < QUIET_LAST) ||
                          $urandom_range(99) >= IDLE_PCT;
            @(posedge clock);
         end
      end
   end

   task automatic send_address(input logic [ADDR_W-1:0] address);
      while (!(accepted >= QUIET_FIRST && accepted < QUIET_LAST) &&
             $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(address);
      do @(posedge clock); while (!req_tready);
      sb.note_access(address);
      accepted++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] index, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.write_register(index, value);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] sets, input logic [WAY_CNT_W-1:0] ways,
                            input bit with_sets, input bit with_ways, input bit with_spare);
      if (with_sets) csr_write(CSR_SET_COUNT, sets);
      // upper data bits are junk for the way count and must be dropped
      if (with_ways) csr_write(CSR_WAY_COUNT, {5'($urandom), ways});
      if (with_spare)
         csr_write(CSR_IDX_W'($urandom_range(CSR_SPARE_FIRST, 2**CSR_IDX_W - 1)),
                   CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   // mostly a small working set of tags around a few sets, some wide random addresses
   task automatic run_phase(input int count);
      int unsigned sets, ways, tag_base, set_base;
      longint unsigned address;
      int i;
      sets = sb.sets_in_use();
      ways = sb.ways_in_use();
      tag_base = 0;
      set_base = 0;
      for (i = 0; i < count; i++) begin
         if (i % 40 == 0) begin
            tag_base = $urandom_range(0, int'(ADDR_MAX / sets) - (ways + 2));
            set_base = $urandom_range(0, sets - 1);
         end
         if ($urandom_range(99) < 75)
            address = longint'(tag_base + $urandom_range(0, ways + 1)) * sets +
                      (set_base + $urandom_range(0, 3)) % sets;
         else
            address = longint'($urandom()) & ADDR_MAX;
         send_address(address[ADDR_W-1:0]);
      end
      drain();
   endtask

   initial begin
      int k, p;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset geometry, 64 sets of 4 ways: hits, fill, round-robin eviction
      send_address('0);
      send_address('0);
      send_address(ADDR_W'(ADDR_MAX));
      send_address(ADDR_W'(ADDR_MAX));
      for (k = 1; k <= 4; k++) send_address(ADDR_W'(64 * k));
      send_address('0);
      send_address(ADDR_W'(64));
      drain();

      // zero counts act as one set of one way
      configure(0, 0, 1'b1, 1'b1, 1'b0);
      send_address(ADDR_W'(5));
      send_address(ADDR_W'(5));
      send_address(ADDR_W'(6));
      send_address(ADDR_W'(5));
      drain();

      // oversized counts saturate, write to an unused index
      configure(300, 15, 1'b1, 1'b1, 1'b1);
      for (k = 0; k <= 8; k++) send_address(ADDR_W'(256 * k + 3));
      drain();

      // shrink the ways without a flush, pointer wraps to the new count
      configure(0, 3, 1'b0, 1'b1, 1'b0);
      send_address(ADDR_W'(256 + 3));
      send_address(ADDR_W'(256 * 9 + 3));
      drain();

      for (p = 0; p < PHASES; p++) begin
         case (p)
            0: configure(1, 1, 1'b1, 1'b1, 1'b0);
            1: configure(256, 8, 1'b1, 1'b1, 1'b0);
            2: configure(2, 3, 1'b1, 1'b1, 1'b1);
            3: configure(511, 9, 1'b1, 1'b1, 1'b0);
            4: configure(0, 8, 1'b1, 1'b1, 1'b0);
            5: configure(256, 1, 1'b1, 1'b1, 1'b0);
            default: configure(CSR_DATA_W'($urandom_range(0, 511)),
                               WAY_CNT_W'($urandom_range(0, 15)),
                               $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0,
                               $urandom_range(0, 1) == 1);
         endcase
         run_phase(PHASE_ITEMS);
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
